// ===== src/framed_line_packet_receiver_unit_macros.svh =====
// Assertion helpers for the framed line packet receiver.
// Both sample on clk_i and are disabled while rst_ni is low.
`ifndef FRAMED_LINE_PACKET_RECEIVER_UNIT_MACROS_SVH
`define FRAMED_LINE_PACKET_RECEIVER_UNIT_MACROS_SVH

// Same-cycle implication.
`define FLPRX_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define FLPRX_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/flprx_pkg.sv =====
`timescale 1ns / 1ps

package flprx_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned RoomW   = 12;
  localparam int unsigned StatusW = 3;
  localparam int unsigned LenW    = 11;
  localparam int unsigned CountW  = 7;

  typedef logic [ByteW-1:0]  byte_t;
  typedef logic [RoomW-1:0]  room_t;
  typedef logic [LenW-1:0]   len_t;
  typedef logic [CountW-1:0] count_t;

  // Framing symbols
  localparam byte_t SymStart = 8'h7E;  // '~'
  localparam byte_t SymLf    = 8'h0A;  // '\n'
  localparam byte_t SymCr    = 8'h0D;  // '\r'

  // Longest payload a single frame may carry
  localparam len_t MaxPayload = 11'd1024;

  typedef enum logic [StatusW-1:0] {
    ST_STORED  = 3'd0,
    ST_IGNORED = 3'd1,
    ST_DROPPED = 3'd2,
    ST_DATA    = 3'd3,
    ST_NODATA  = 3'd4,
    ST_SMALL   = 3'd5
  } status_e;

  typedef enum logic {
    FUNC_RX   = 1'b0,
    FUNC_READ = 1'b1
  } func_e;

  typedef struct packed {
    logic  func;
    byte_t rx_byte;
    room_t room;
  } item_t;

  typedef struct packed {
    status_e status;
    byte_t   data_byte;
    logic    last;
    len_t    packet_length;
    count_t  packets_ready;
  } result_t;

endpackage

// ===== src/flprx_if.sv =====
`timescale 1ns / 1ps

interface flprx_item_if;
  logic                valid;
  logic                ready;
  logic                func;
  flprx_pkg::byte_t    rx_byte;
  flprx_pkg::room_t    room;

  modport source (output valid, func, rx_byte, room, input ready);
  modport sink   (input valid, func, rx_byte, room, output ready);
endinterface

interface flprx_result_if;
  logic                valid;
  logic                ready;
  flprx_pkg::status_e  status;
  flprx_pkg::byte_t    data_byte;
  logic                last;
  flprx_pkg::len_t     packet_length;
  flprx_pkg::count_t   packets_ready;

  modport source (output valid, status, data_byte, last, packet_length, packets_ready,
                  input ready);
  modport sink   (input valid, status, data_byte, last, packet_length, packets_ready,
                  output ready);
endinterface

// ===== src/flprx_byte_store.sv =====
`timescale 1ns / 1ps

module flprx_byte_store #(
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AddrW = $clog2(DEPTH)
) (
  input  logic                   clk_i,
  input  logic                   we_i,
  input  logic [AddrW-1:0]       waddr_i,
  input  flprx_pkg::byte_t       wdata_i,
  input  logic                   re_i,
  input  logic [AddrW-1:0]       raddr_i,
  output flprx_pkg::byte_t       rdata_o
);

  flprx_pkg::byte_t mem_q [DEPTH];
  flprx_pkg::byte_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/flprx_len_queue.sv =====
`timescale 1ns / 1ps

module flprx_len_queue #(
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic               clk_i,
  input  logic               we_i,
  input  logic [AddrW-1:0]   waddr_i,
  input  flprx_pkg::len_t    wdata_i,
  input  logic [AddrW-1:0]   raddr_i,
  output flprx_pkg::len_t    head_len_o
);

  flprx_pkg::len_t mem_q [DEPTH];
  flprx_pkg::len_t head_q;

  // Prefetch the entry at the next head index; forward a push into that slot.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (we_i && (waddr_i == raddr_i)) begin
      head_q <= wdata_i;
    end else begin
      head_q <= mem_q[raddr_i];
    end
  end

  assign head_len_o = head_q;

endmodule

// ===== src/flprx_ctrl.sv =====
`timescale 1ns / 1ps

module flprx_ctrl #(
  parameter int unsigned STORE_DEPTH = 1024,
  parameter int unsigned MAX_PACKETS = 64,
  localparam int unsigned PtrW  = $clog2(STORE_DEPTH),
  localparam int unsigned FillW = $clog2(STORE_DEPTH + 1),
  localparam int unsigned QIdxW = (MAX_PACKETS > 1) ? $clog2(MAX_PACKETS) : 1,
  localparam int unsigned CntW  = $clog2(MAX_PACKETS + 1),
  localparam int unsigned RollW = ((FillW > flprx_pkg::LenW) ? FillW : flprx_pkg::LenW) + 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  flprx_pkg::item_t    item_i,
  output flprx_pkg::result_t  res_o,
  output logic                take_o,
  output logic                st_we_o,
  output logic [PtrW-1:0]     st_waddr_o,
  output flprx_pkg::byte_t    st_wdata_o,
  output logic [PtrW-1:0]     st_raddr_o,
  output logic                lq_we_o,
  output logic [QIdxW-1:0]    lq_waddr_o,
  output flprx_pkg::len_t     lq_wdata_o,
  output logic [QIdxW-1:0]    lq_raddr_o,
  input  flprx_pkg::len_t     lq_head_len_i
);

  logic [PtrW-1:0]   wp_q, wp_d, rp_q, rp_d, wp_inc, rp_inc, wp_back;
  logic [FillW-1:0]  fill_q, fill_d;
  logic              inside_q, inside_d;
  flprx_pkg::len_t   open_q, open_d, off_q, off_d, off_next, head_len;
  logic [QIdxW-1:0]  head_q, head_d, head_inc;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [QIdxW:0]    tail_raw, tail_wrap;
  logic [RollW-1:0]  roll, roll_wrap;
  logic              is_end, store_full, q_full, st_we, lq_we, take;

  // Index arithmetic with wrap for any depth
  always_comb begin
    wp_inc   = (wp_q == PtrW'(STORE_DEPTH - 1)) ? '0 : wp_q + 1'b1;
    rp_inc   = (rp_q == PtrW'(STORE_DEPTH - 1)) ? '0 : rp_q + 1'b1;
    head_inc = (head_q == QIdxW'(MAX_PACKETS - 1)) ? '0 : head_q + 1'b1;

    tail_raw  = {1'b0, head_q} + {1'b0, cnt_q[QIdxW-1:0]};
    tail_wrap = tail_raw - (QIdxW + 1)'(MAX_PACKETS);

    roll      = RollW'(wp_q) - RollW'(open_q);
    roll_wrap = roll + RollW'(STORE_DEPTH);
    wp_back   = roll[RollW-1] ? roll_wrap[PtrW-1:0] : roll[PtrW-1:0];
  end

  assign head_len   = (cnt_q == '0) ? '0 : lq_head_len_i;
  assign is_end     = (item_i.rx_byte == flprx_pkg::SymLf) ||
                      (item_i.rx_byte == flprx_pkg::SymCr);
  assign store_full = (fill_q == FillW'(STORE_DEPTH));
  assign q_full     = (cnt_q == CntW'(MAX_PACKETS));

  always_comb begin
    wp_d     = wp_q;
    rp_d     = rp_q;
    fill_d   = fill_q;
    inside_d = inside_q;
    open_d   = open_q;
    off_d    = off_q;
    head_d   = head_q;
    cnt_d    = cnt_q;
    st_we    = 1'b0;
    lq_we    = 1'b0;
    take     = 1'b0;
    off_next = off_q;

    res_o.status        = flprx_pkg::ST_STORED;
    res_o.data_byte     = '0;
    res_o.last          = 1'b0;
    res_o.packet_length = head_len;

    unique case (flprx_pkg::func_e'(item_i.func))
      flprx_pkg::FUNC_RX: begin
        priority if (!inside_q) begin
          if (item_i.rx_byte == flprx_pkg::SymStart) begin
            inside_d = 1'b1;
            open_d   = '0;
          end else begin
            res_o.status = flprx_pkg::ST_IGNORED;
          end
        end else if (is_end) begin
          inside_d = 1'b0;
          open_d   = '0;
          if (q_full) begin
            // Discard the open frame and give its bytes back
            wp_d         = wp_back;
            fill_d       = fill_q - FillW'(open_q);
            res_o.status = flprx_pkg::ST_DROPPED;
          end else begin
            lq_we = 1'b1;
            cnt_d = cnt_q + 1'b1;
            if (cnt_q == '0) begin
              res_o.packet_length = open_q;
            end
          end
        end else if (store_full || (open_q >= flprx_pkg::MaxPayload)) begin
          res_o.status = flprx_pkg::ST_DROPPED;
        end else begin
          st_we  = 1'b1;
          wp_d   = wp_inc;
          fill_d = fill_q + 1'b1;
          open_d = open_q + 1'b1;
        end
      end
      flprx_pkg::FUNC_READ: begin
        priority if (cnt_q == '0) begin
          res_o.status = flprx_pkg::ST_NODATA;
        end else if ((off_q == '0) &&
                     ({1'b0, head_len} >= item_i.room)) begin
          res_o.status = flprx_pkg::ST_SMALL;
        end else begin
          res_o.status = flprx_pkg::ST_DATA;
          take         = (off_q < head_len) && (fill_q != '0);
          if (take) begin
            rp_d     = rp_inc;
            fill_d   = fill_q - 1'b1;
            off_next = off_q + 1'b1;
          end
          if (off_next >= head_len) begin
            res_o.last = 1'b1;
            off_d      = '0;
            head_d     = head_inc;
            cnt_d      = cnt_q - 1'b1;
          end else begin
            off_d = off_next;
          end
        end
      end
      default: begin
        res_o.status = flprx_pkg::ST_IGNORED;
      end
    endcase

    res_o.packets_ready = flprx_pkg::count_t'(cnt_d);
  end

  assign take_o     = take;
  assign st_we_o    = adv_i && st_we;
  assign st_waddr_o = wp_q;
  assign st_wdata_o = item_i.rx_byte;
  assign st_raddr_o = rp_q;
  assign lq_we_o    = adv_i && lq_we;
  assign lq_waddr_o = (tail_raw >= (QIdxW + 1)'(MAX_PACKETS)) ? tail_wrap[QIdxW-1:0]
                                                              : tail_raw[QIdxW-1:0];
  assign lq_wdata_o = open_q;
  // Head index after this beat; the queue prefetches that entry.
  assign lq_raddr_o = adv_i ? head_d : head_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q     <= '0;
      rp_q     <= '0;
      fill_q   <= '0;
      inside_q <= 1'b0;
      open_q   <= '0;
      off_q    <= '0;
      head_q   <= '0;
      cnt_q    <= '0;
    end else if (adv_i) begin
      wp_q     <= wp_d;
      rp_q     <= rp_d;
      fill_q   <= fill_d;
      inside_q <= inside_d;
      open_q   <= open_d;
      off_q    <= off_d;
      head_q   <= head_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

// ===== src/framed_line_packet_receiver_unit.sv =====
`timescale 1ns / 1ps

// Framed line packet receiver. Each input beat is either a received serial
// byte (func 0) or a request for the next byte of the oldest complete packet
// (func 1), and each beat yields exactly one result beat. Bytes outside a
// frame are ignored until '~' opens one; payload is then kept in a circular
// byte store of STORE_DEPTH entries until '\n' or '\r' closes the packet and
// its length joins a queue of up to MAX_PACKETS lengths. A read returns one
// payload byte per beat with the packet length and a last flag, reports
// no data when the queue is empty, and reports too small (leaving the packet
// in place) when the length is not below room at the first byte. Payload
// bytes that meet a full store or a 1024-byte frame are dropped; a frame that
// closes while the length queue is full is discarded whole. Timing: each
// accepted beat sits in the input register, then the result register loads
// alongside the store's registered read, and the result appears on the port.
// One beat is accepted every cycle as long as results are taken; the rate
// is set by the single access per beat to the byte store. The result
// register and the input register are decoupled, so a new beat is accepted
// while a finished result waits. No clearing pass is needed after reset: the
// store and the length queue are only read at entries already written.
module framed_line_packet_receiver_unit #(
  parameter int unsigned STORE_DEPTH = 1024,
  parameter int unsigned MAX_PACKETS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  flprx_item_if.sink         item_i,
  flprx_result_if.source     result_o
);

  localparam int unsigned PtrW  = $clog2(STORE_DEPTH);
  localparam int unsigned QIdxW = (MAX_PACKETS > 1) ? $clog2(MAX_PACKETS) : 1;

  // Input register
  logic               a_vld_q;
  flprx_pkg::item_t   a_item_q;
  // Result register
  logic               b_vld_q;
  logic               b_take_q;
  flprx_pkg::result_t b_res_q;

  logic               adv;
  logic               take;
  flprx_pkg::result_t res;

  logic               st_we;
  logic [PtrW-1:0]    st_waddr, st_raddr;
  flprx_pkg::byte_t   st_wdata, st_rdata;
  logic               lq_we;
  logic [QIdxW-1:0]   lq_waddr, lq_raddr;
  flprx_pkg::len_t    lq_wdata, lq_head_len;

  // Advance the held beat whenever the result register is free or draining.
  assign adv          = a_vld_q && (!b_vld_q || result_o.ready);
  assign item_i.ready = !a_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
    end else begin
      if (item_i.valid && item_i.ready) begin
        a_vld_q <= 1'b1;
      end else if (adv) begin
        a_vld_q <= 1'b0;
      end
      if (adv) begin
        b_vld_q <= 1'b1;
      end else if (result_o.ready) begin
        b_vld_q <= 1'b0;
      end
    end
  end

  // Payload: load on accept, hold otherwise; the result register loads on advance.
  always_ff @(posedge clk_i) begin
    if (item_i.valid && item_i.ready) begin
      a_item_q.func    <= item_i.func;
      a_item_q.rx_byte <= item_i.rx_byte;
      a_item_q.room    <= item_i.room;
    end
    if (adv) begin
      b_res_q  <= res;
      b_take_q <= take;
    end
  end

  flprx_ctrl #(
    .STORE_DEPTH (STORE_DEPTH),
    .MAX_PACKETS (MAX_PACKETS)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .adv_i         (adv),
    .item_i        (a_item_q),
    .res_o         (res),
    .take_o        (take),
    .st_we_o       (st_we),
    .st_waddr_o    (st_waddr),
    .st_wdata_o    (st_wdata),
    .st_raddr_o    (st_raddr),
    .lq_we_o       (lq_we),
    .lq_waddr_o    (lq_waddr),
    .lq_wdata_o    (lq_wdata),
    .lq_raddr_o    (lq_raddr),
    .lq_head_len_i (lq_head_len)
  );

  // The store read lands in its output register on the same edge the result
  // register loads, so the byte lines up with the rest of the result.
  flprx_byte_store #(
    .DEPTH (STORE_DEPTH)
  ) u_byte_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .re_i    (adv && take),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  flprx_len_queue #(
    .DEPTH (MAX_PACKETS)
  ) u_len_queue (
    .clk_i      (clk_i),
    .we_i       (lq_we),
    .waddr_i    (lq_waddr),
    .wdata_i    (lq_wdata),
    .raddr_i    (lq_raddr),
    .head_len_o (lq_head_len)
  );

  assign result_o.valid         = b_vld_q;
  assign result_o.status        = b_res_q.status;
  assign result_o.data_byte     = b_take_q ? st_rdata : b_res_q.data_byte;
  assign result_o.last          = b_res_q.last;
  assign result_o.packet_length = b_res_q.packet_length;
  assign result_o.packets_ready = b_res_q.packets_ready;

endmodule

// ===== src/flprx_checker.sv =====
`timescale 1ns / 1ps
`include "framed_line_packet_receiver_unit_macros.svh"

module flprx_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input flprx_pkg::status_e  status_i,
  input flprx_pkg::byte_t    data_byte_i,
  input logic                last_i,
  input flprx_pkg::len_t     packet_length_i,
  input flprx_pkg::count_t   packets_ready_i
);

  `FLPRX_ASSERT_NEXT(a_result_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(status_i) && $stable(data_byte_i) && $stable(last_i) && $stable(packet_length_i) && $stable(packets_ready_i), "stalled result changed")
  `FLPRX_ASSERT_IMPL(a_nondata_quiet, out_valid_i && (status_i != flprx_pkg::ST_DATA), (data_byte_i == '0) && !last_i, "byte or last flag outside a data result")
  `FLPRX_ASSERT_IMPL(a_nodata_empty, out_valid_i && (status_i == flprx_pkg::ST_NODATA), (packet_length_i == '0) && (packets_ready_i == '0), "no-data result reports a packet")

endmodule

bind framed_line_packet_receiver_unit flprx_checker u_flprx_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (result_o.valid),
  .out_ready_i     (result_o.ready),
  .status_i        (result_o.status),
  .data_byte_i     (result_o.data_byte),
  .last_i          (result_o.last),
  .packet_length_i (result_o.packet_length),
  .packets_ready_i (result_o.packets_ready)
);
